// ----- rtl/mlc_pkg.sv -----
// ----------------------------------------------------------------------------
// mlc_pkg
// shared types, constants and helpers for the moment limiter cascade
// ----------------------------------------------------------------------------
package mlc_pkg;

    localparam int unsigned MLC_DATA_W  = 32;
    localparam int unsigned MLC_NUM_MOM = 4;
    localparam int unsigned MLC_COEF_W  = 31;
    localparam int unsigned MLC_PROD_W  = 63;
    localparam int unsigned MLC_ORD_W   = 3;
    localparam int unsigned MLC_VIS_W   = 3;
    localparam int unsigned MLC_TOP_W   = 2;

    localparam logic [MLC_ORD_W-1:0] MLC_ORDER_RESET = 3'd5;

    // unsigned q0.31 scale factors sqrt((2k-1)/(2k+1)), k = 1..4
    localparam logic [MLC_COEF_W-1:0] MLC_COEF [MLC_NUM_MOM] = '{
        31'd1239850262, 31'd1663433681, 31'd1814954942, 31'd1893902559
    };

    typedef logic signed [MLC_DATA_W-1:0] t_data;

    // per-stage load enables for the lanes
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

    // index of the top limited moment (0 = first higher moment)
    function automatic logic [MLC_TOP_W-1:0] mlc_top_idx(input logic [MLC_ORD_W-1:0] ord);
        logic [MLC_TOP_W-1:0] idx;
        begin
            unique case (ord)
                3'd0, 3'd1, 3'd2: idx = 2'd0;
                3'd3:             idx = 2'd1;
                3'd4:             idx = 2'd2;
                default:          idx = 2'd3;
            endcase
            return idx;
        end
    endfunction

endpackage

// ----- rtl/mlc_in_if.sv -----
// ----------------------------------------------------------------------------
// mlc_in_if
// input channel: one cell's higher moments and neighbor differences
// ----------------------------------------------------------------------------
interface mlc_in_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   moment_one;
    logic signed [31:0]   moment_two;
    logic signed [31:0]   moment_three;
    logic signed [31:0]   moment_four;
    logic signed [31:0]   right_diff_one;
    logic signed [31:0]   right_diff_two;
    logic signed [31:0]   right_diff_three;
    logic signed [31:0]   right_diff_four;
    logic signed [31:0]   left_diff_one;
    logic signed [31:0]   left_diff_two;
    logic signed [31:0]   left_diff_three;
    logic signed [31:0]   left_diff_four;

    modport source (
        output valid, moment_one, moment_two, moment_three, moment_four,
               right_diff_one, right_diff_two, right_diff_three, right_diff_four,
               left_diff_one, left_diff_two, left_diff_three, left_diff_four,
        input  ready
    );

    modport sink (
        input  valid, moment_one, moment_two, moment_three, moment_four,
               right_diff_one, right_diff_two, right_diff_three, right_diff_four,
               left_diff_one, left_diff_two, left_diff_three, left_diff_four,
        output ready
    );
endinterface

// ----- rtl/mlc_out_if.sv -----
// ----------------------------------------------------------------------------
// mlc_out_if
// output channel: limited moments and cascade depth
// ----------------------------------------------------------------------------
interface mlc_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   limited_one;
    logic signed [31:0]   limited_two;
    logic signed [31:0]   limited_three;
    logic signed [31:0]   limited_four;
    logic        [2:0]    levels_visited;

    modport source (
        output valid, limited_one, limited_two, limited_three, limited_four,
               levels_visited,
        input  ready
    );

    modport sink (
        input  valid, limited_one, limited_two, limited_three, limited_four,
               levels_visited,
        output ready
    );
endinterface

// ----- rtl/mlc_lane.sv -----
// ----------------------------------------------------------------------------
// mlc_lane
// three-stage datapath for one moment: scale both differences, then minmod
// ----------------------------------------------------------------------------
module mlc_lane #(
    parameter logic [mlc_pkg::MLC_COEF_W-1:0] P_COEF = mlc_pkg::MLC_COEF[0]
) (
    input  logic               i_clk,
    input  mlc_pkg::t_stage_en i_en,
    input  mlc_pkg::t_data     i_mom,
    input  mlc_pkg::t_data     i_rd,
    input  mlc_pkg::t_data     i_ld,
    output mlc_pkg::t_data     o_old,
    output mlc_pkg::t_data     o_lim,
    output logic               o_cont
);
    import mlc_pkg::*;

    localparam logic signed [MLC_PROD_W-1:0] RND = MLC_PROD_W'(64'sd1 <<< 30);

    logic signed [MLC_DATA_W-1:0]   w_coef;
    logic signed [2*MLC_DATA_W-1:0] w_prod_r;
    logic signed [2*MLC_DATA_W-1:0] w_prod_l;
    logic signed [MLC_PROD_W-1:0]   w_sum_r;
    logic signed [MLC_PROD_W-1:0]   w_sum_l;

    logic signed [MLC_PROD_W-1:0]   r_prod_r;
    logic signed [MLC_PROD_W-1:0]   r_prod_l;
    t_data                          r_mom1;
    t_data                          r_sc_r;
    t_data                          r_sc_l;
    t_data                          r_mom2;
    t_data                          r_old3;
    t_data                          r_lim3;
    logic                           r_cont3;

    t_data                          n_lim;

    assign w_coef   = $signed({1'b0, P_COEF});
    assign w_prod_r = i_rd * w_coef;
    assign w_prod_l = i_ld * w_coef;
    assign w_sum_r  = r_prod_r + RND;
    assign w_sum_l  = r_prod_l + RND;

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_prod_r <= w_prod_r[MLC_PROD_W-1:0];
            r_prod_l <= w_prod_l[MLC_PROD_W-1:0];
            r_mom1   <= i_mom;
        end
    end

    // stage 2: round, floor shift by 31
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_sc_r <= w_sum_r[MLC_PROD_W-1:MLC_COEF_W];
            r_sc_l <= w_sum_l[MLC_PROD_W-1:MLC_COEF_W];
            r_mom2 <= r_mom1;
        end
    end

    // stage 3: minmod of moment and both scaled differences
    always_comb begin
        n_lim = '0;
        if (r_mom2 > 0 && r_sc_r > 0 && r_sc_l > 0) begin
            n_lim = r_mom2;
            if (r_sc_r < n_lim) n_lim = r_sc_r;
            if (r_sc_l < n_lim) n_lim = r_sc_l;
        end else if (r_mom2 < 0 && r_sc_r < 0 && r_sc_l < 0) begin
            n_lim = r_mom2;
            if (r_sc_r > n_lim) n_lim = r_sc_r;
            if (r_sc_l > n_lim) n_lim = r_sc_l;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_old3  <= r_mom2;
            r_lim3  <= n_lim;
            r_cont3 <= (n_lim != r_mom2) || (n_lim == '0);
        end
    end

    assign o_old  = r_old3;
    assign o_lim  = r_lim3;
    assign o_cont = r_cont3;

endmodule

// ----- rtl/moment_limiter_cascade.sv -----
// ----------------------------------------------------------------------------
// moment_limiter_cascade
// minmod moment limiter cascade for one cell, top moment downward
// ----------------------------------------------------------------------------
// throughput: one item per cycle, set by the four-stage pipeline (multiply,
//   round, minmod, cascade select); a stalled output holds the pipeline
// reset: synchronous active-low i_rst_n clears all valid bits and sets order to 5
module moment_limiter_cascade (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mlc_pkg::MLC_ORD_W-1:0]   i_cfg_wdata,
    mlc_in_if.sink                          i_in,
    mlc_out_if.source                       o_out
);
    import mlc_pkg::*;

    logic [MLC_ORD_W-1:0]  r_order;
    logic                  r_v1, r_v2, r_v3, r_v4;
    logic [MLC_TOP_W-1:0]  r_top1, r_top2, r_top3, r_top4;
    t_data                 r_res [MLC_NUM_MOM];
    logic [MLC_VIS_W-1:0]  r_vis;

    logic                  w_en1, w_en2, w_en3, w_en4;
    t_stage_en             w_en;
    t_data                 w_mom [MLC_NUM_MOM];
    t_data                 w_rd  [MLC_NUM_MOM];
    t_data                 w_ld  [MLC_NUM_MOM];
    t_data                 w_old [MLC_NUM_MOM];
    t_data                 w_lim [MLC_NUM_MOM];
    logic [MLC_NUM_MOM-1:0] w_cont;

    t_data                 n_res [MLC_NUM_MOM];
    logic [MLC_VIS_W-1:0]  n_vis;

    // each stage moves when it is empty or the one after it moves
    assign w_en4 = !r_v4 || o_out.ready;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign w_en  = '{s1: w_en1, s2: w_en2, s3: w_en3};

    assign i_in.ready = w_en1;

    assign w_mom = '{i_in.moment_one, i_in.moment_two, i_in.moment_three, i_in.moment_four};
    assign w_rd  = '{i_in.right_diff_one, i_in.right_diff_two,
                     i_in.right_diff_three, i_in.right_diff_four};
    assign w_ld  = '{i_in.left_diff_one, i_in.left_diff_two,
                     i_in.left_diff_three, i_in.left_diff_four};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= MLC_ORDER_RESET;
        end else if (i_cfg_we) begin
            r_order <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_in.valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) r_top1 <= mlc_top_idx(r_order);
        if (w_en2) r_top2 <= r_top1;
        if (w_en3) r_top3 <= r_top2;
        if (w_en4) r_top4 <= r_top3;
    end

    for (genvar g = 0; g < MLC_NUM_MOM; g++) begin : g_lane
        mlc_lane #(
            .P_COEF (MLC_COEF[g])
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_mom  (w_mom[g]),
            .i_rd   (w_rd[g]),
            .i_ld   (w_ld[g]),
            .o_old  (w_old[g]),
            .o_lim  (w_lim[g]),
            .o_cont (w_cont[g])
        );
    end

    // cascade: walk from the top moment down while each limit changed or hit zero
    always_comb begin
        logic going;
        going = 1'b1;
        n_vis = '0;
        for (int k = MLC_NUM_MOM - 1; k >= 0; k--) begin
            if (going && (k <= int'(r_top3))) begin
                n_res[k] = w_lim[k];
                n_vis    = n_vis + 3'd1;
                if (!w_cont[k]) going = 1'b0;
            end else begin
                n_res[k] = w_old[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_res <= n_res;
            r_vis <= n_vis;
        end
    end

    assign o_out.valid          = r_v4;
    assign o_out.limited_one    = r_res[0];
    assign o_out.limited_two    = r_res[1];
    assign o_out.limited_three  = r_res[2];
    assign o_out.limited_four   = r_res[3];
    assign o_out.levels_visited = r_vis;

    a_vis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_vis != 3'd0) && (r_vis <= 3'd4))
        else $error("levels_visited out of range");

    a_vis_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_vis <= ({1'b0, r_top4} + 3'd1)))
        else $error("cascade went past the top moment");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v4 |-> i_in.ready)
        else $error("input stalled with an empty output register");

    a_hold_s3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !w_en3) |=> r_v3)
        else $error("stage three item lost while stalled");

endmodule

// ----- tb/mlc_limit_checker.sv -----
// ----------------------------------------------------------------------------
// mlc_limit_checker
// watches both channels of the moment limiter, predicts each limited cell
// from the accepted inputs and the order register, and compares in order
// ----------------------------------------------------------------------------
module mlc_limit_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mlc_pkg::MLC_ORD_W-1:0] i_cfg_wdata,
    mlc_in_if                             i_cell_ch,
    mlc_out_if                            i_limited_ch,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_results,
    output int                            o_full_depth
);
    import mlc_pkg::*;

    typedef struct packed {
        t_data      one;
        t_data      two;
        t_data      three;
        t_data      four;
        logic [2:0] levels;
    } t_limited;

    t_limited             expected_limited [$];
    t_limited             oldest;
    logic [MLC_ORD_W-1:0] order_q = MLC_ORDER_RESET;
    t_data                cell_m [4];
    t_data                cell_r [4];
    t_data                cell_l [4];
    int                   fails = 0;
    int                   results = 0;
    int                   full_depth = 0;

    // floor((d * c + 2^30) / 2^31), c is unsigned q0.31
    function automatic t_data scale_by_coef(input t_data d, input logic [MLC_COEF_W-1:0] c);
        longint prod;
        longint scaled;
        begin
            prod   = longint'(d) * longint'({33'd0, c}) + (64'sd1 <<< 30);
            scaled = prod >>> 31;
            return scaled[31:0];
        end
    endfunction

    function automatic t_data minmod_of_three(input t_data a, input t_data b, input t_data c);
        t_data pick;
        begin
            pick = '0;
            if (a > 0 && b > 0 && c > 0) begin
                pick = a;
                if (b < pick) pick = b;
                if (c < pick) pick = c;
            end else if (a < 0 && b < 0 && c < 0) begin
                pick = a;
                if (b > pick) pick = b;
                if (c > pick) pick = c;
            end
            return pick;
        end
    endfunction

    function automatic t_limited limit_cell(input t_data m [4], input t_data r [4],
                                            input t_data l [4],
                                            input logic [MLC_ORD_W-1:0] ord);
        t_data    mom [4];
        t_data    old;
        t_data    lim;
        t_limited res;
        int       top;
        int       visited;
        logic     going;
        begin
            for (int k = 0; k < 4; k++) mom[k] = m[k];
            // orders below 2 act as 2, above 5 act as 5
            top = int'(ord) - 1;
            if (top < 1) top = 1;
            if (top > 4) top = 4;
            visited = 0;
            going   = 1'b1;
            for (int k = top - 1; k >= 0; k--) begin
                if (going) begin
                    old = mom[k];
                    lim = minmod_of_three(old, scale_by_coef(r[k], MLC_COEF[k]),
                                          scale_by_coef(l[k], MLC_COEF[k]));
                    mom[k]  = lim;
                    visited = visited + 1;
                    // an untouched nonzero moment ends the cascade
                    if (lim == old && lim != 0) going = 1'b0;
                end
            end
            res.one    = mom[0];
            res.two    = mom[1];
            res.three  = mom[2];
            res.four   = mom[3];
            res.levels = visited[2:0];
            return res;
        end
    endfunction

    task automatic check_field(input string name, input t_data want, input t_data got);
        begin
            if (want !== got) begin
                fails = fails + 1;
                $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            order_q = MLC_ORDER_RESET;
        end else begin
            if (i_cell_ch.valid && i_cell_ch.ready) begin
                cell_m[0] = i_cell_ch.moment_one;
                cell_m[1] = i_cell_ch.moment_two;
                cell_m[2] = i_cell_ch.moment_three;
                cell_m[3] = i_cell_ch.moment_four;
                cell_r[0] = i_cell_ch.right_diff_one;
                cell_r[1] = i_cell_ch.right_diff_two;
                cell_r[2] = i_cell_ch.right_diff_three;
                cell_r[3] = i_cell_ch.right_diff_four;
                cell_l[0] = i_cell_ch.left_diff_one;
                cell_l[1] = i_cell_ch.left_diff_two;
                cell_l[2] = i_cell_ch.left_diff_three;
                cell_l[3] = i_cell_ch.left_diff_four;
                expected_limited.push_back(limit_cell(cell_m, cell_r, cell_l, order_q));
            end
            if (i_limited_ch.valid && i_limited_ch.ready) begin
                if (expected_limited.size() == 0) begin
                    fails = fails + 1;
                    $display("%0t unexpected result: expected none actual %0d %0d %0d %0d %0d",
                             $time, i_limited_ch.limited_one, i_limited_ch.limited_two,
                             i_limited_ch.limited_three, i_limited_ch.limited_four,
                             i_limited_ch.levels_visited);
                end else begin
                    oldest = expected_limited.pop_front();
                    check_field("limited_one", oldest.one, i_limited_ch.limited_one);
                    check_field("limited_two", oldest.two, i_limited_ch.limited_two);
                    check_field("limited_three", oldest.three, i_limited_ch.limited_three);
                    check_field("limited_four", oldest.four, i_limited_ch.limited_four);
                    check_field("levels_visited", t_data'(oldest.levels),
                                t_data'(i_limited_ch.levels_visited));
                    results = results + 1;
                    if (oldest.levels == 3'd4) full_depth = full_depth + 1;
                end
            end
            if (i_cfg_we) order_q = i_cfg_wdata;
        end
        o_fail_count <= fails;
        o_pending    <= expected_limited.size();
        o_results    <= results;
        o_full_depth <= full_depth;
    end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// stimulus for the moment limiter cascade: directed corner cells, then
// random cells over every order setting with idle bursts and a long
// receiver hold-off; the checker beside the block judges every result
// ----------------------------------------------------------------------------
module tb;
    import mlc_pkg::*;

    localparam int    WATCHDOG_LIMIT = 2000;
    localparam int    HOLD_CYCLES    = 150;
    localparam int    SETTLE_CYCLES  = 8;
    localparam int    PHASE_CELLS    = 110;
    localparam int    LAST_CELLS     = 130;
    localparam t_data MAX_VAL        = 32'sh7fffffff;
    localparam t_data MIN_VAL        = 32'sh80000000;

    typedef enum int {CELL_DEEP, CELL_SMALL, CELL_NOISE} t_cell_style;
    typedef enum int {LEVEL_CHANGE, LEVEL_ZERO, LEVEL_KEEP} t_level_kind;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [MLC_ORD_W-1:0] i_cfg_wdata;

    mlc_in_if  in_ch ();
    mlc_out_if out_ch ();

    int    fail_count;
    int    pending;
    int    results;
    int    full_depth;
    int    quiet_cycles;
    int    cells_sent;
    bit    idle_on;
    bit    hold_req;
    bit    hold_done;
    t_data cell_mom [4];
    t_data cell_rd [4];
    t_data cell_ld [4];

    logic [MLC_ORD_W-1:0] phase_order [8] = '{3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd6, 3'd7, 3'd5};

    moment_limiter_cascade dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    mlc_limit_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cell_ch    (in_ch),
        .i_limited_ch (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_full_depth (full_depth)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // magnitude in [1, 2^30) with a random bit length
    function automatic int unsigned rand_mag();
        int unsigned bits;
        int unsigned v;
        begin
            bits = $urandom_range(1, 30);
            v    = $urandom >> (32 - bits);
            if (v == 0) v = 1;
            return v;
        end
    endfunction

    function automatic t_data with_sign(input int unsigned mag, input bit neg);
        begin
            return neg ? -t_data'(mag) : t_data'(mag);
        end
    endfunction

    task automatic set_level(input int k, input t_data m, input t_data r, input t_data l);
        begin
            cell_mom[k] = m;
            cell_rd[k]  = r;
            cell_ld[k]  = l;
        end
    endtask

    task automatic fill_all(input t_data m, input t_data r, input t_data l);
        begin
            for (int k = 0; k < 4; k++) set_level(k, m, r, l);
        end
    endtask

    task automatic gen_level(input int k);
        t_level_kind kind;
        int unsigned mag;
        int unsigned pick;
        bit          neg;
        begin
            pick = $urandom_range(0, 9);
            neg  = $urandom_range(0, 1);
            mag  = rand_mag();
            kind = (pick <= 6) ? LEVEL_CHANGE : (pick == 7) ? LEVEL_ZERO : LEVEL_KEEP;
            case (kind)
                LEVEL_CHANGE: begin
                    // scaled differences below the moment, so it gets clipped
                    set_level(k, with_sign(mag, neg), with_sign($urandom_range(0, mag), neg),
                              with_sign($urandom_range(0, mag), neg));
                end
                LEVEL_ZERO: begin
                    if ($urandom_range(0, 1)) begin
                        set_level(k, '0, with_sign(rand_mag(), $urandom_range(0, 1)),
                                  with_sign(rand_mag(), $urandom_range(0, 1)));
                    end else if ($urandom_range(0, 1)) begin
                        set_level(k, with_sign(mag, neg), with_sign(rand_mag(), !neg),
                                  with_sign(rand_mag(), neg));
                    end else begin
                        set_level(k, with_sign(mag, neg), with_sign(rand_mag(), neg),
                                  with_sign(rand_mag(), !neg));
                    end
                end
                default: begin
                    // differences well above the moment, so it stays as is
                    mag = (mag >> 2) | 1;
                    set_level(k, with_sign(mag, neg),
                              with_sign(2 * mag + $urandom_range(0, mag), neg),
                              with_sign(2 * mag + $urandom_range(0, mag), neg));
                end
            endcase
        end
    endtask

    task automatic gen_cell();
        t_cell_style style;
        int unsigned pick;
        begin
            pick  = $urandom_range(0, 99);
            style = (pick < 70) ? CELL_DEEP : (pick < 85) ? CELL_SMALL : CELL_NOISE;
            for (int k = 0; k < 4; k++) begin
                case (style)
                    CELL_DEEP:  gen_level(k);
                    CELL_SMALL: set_level(k, $urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
                                          $urandom_range(0, 6) - 3);
                    default:    set_level(k, $urandom, $urandom, $urandom);
                endcase
            end
        end
    endtask

    task automatic send_cell();
        begin
            if (idle_on && $urandom_range(0, 7) == 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            in_ch.valid            <= 1'b1;
            in_ch.moment_one       <= cell_mom[0];
            in_ch.moment_two       <= cell_mom[1];
            in_ch.moment_three     <= cell_mom[2];
            in_ch.moment_four      <= cell_mom[3];
            in_ch.right_diff_one   <= cell_rd[0];
            in_ch.right_diff_two   <= cell_rd[1];
            in_ch.right_diff_three <= cell_rd[2];
            in_ch.right_diff_four  <= cell_rd[3];
            in_ch.left_diff_one    <= cell_ld[0];
            in_ch.left_diff_two    <= cell_ld[1];
            in_ch.left_diff_three  <= cell_ld[2];
            in_ch.left_diff_four   <= cell_ld[3];
            @(posedge i_clk);
            while (!in_ch.ready) @(posedge i_clk);
            cells_sent = cells_sent + 1;
        end
    endtask

    task automatic drain();
        begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
            while (pending != 0) @(posedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end
    endtask

    task automatic write_order(input logic [MLC_ORD_W-1:0] value);
        begin
            drain();
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= value;
            @(posedge i_clk);
            i_cfg_we    <= 1'b0;
        end
    endtask

    // receiver: idle bursts, plus one long hold-off while the sender keeps going
    initial begin
        out_ch.ready <= 1'b0;
        hold_done = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no item moved for %0d cycles", $time, quiet_cycles);
            $display("FAIL moment_limiter_cascade");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n                <= 1'b0;
        i_cfg_we               <= 1'b0;
        i_cfg_wdata            <= '0;
        in_ch.valid            <= 1'b0;
        in_ch.moment_one       <= '0;
        in_ch.moment_two       <= '0;
        in_ch.moment_three     <= '0;
        in_ch.moment_four      <= '0;
        in_ch.right_diff_one   <= '0;
        in_ch.right_diff_two   <= '0;
        in_ch.right_diff_three <= '0;
        in_ch.right_diff_four  <= '0;
        in_ch.left_diff_one    <= '0;
        in_ch.left_diff_two    <= '0;
        in_ch.left_diff_three  <= '0;
        in_ch.left_diff_four   <= '0;
        cells_sent   = 0;
        idle_on      = 1'b1;
        hold_req     = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed cells at the reset order, all four levels live
        fill_all('0, '0, '0);
        send_cell();
        fill_all(MAX_VAL, MAX_VAL, MAX_VAL);
        send_cell();
        fill_all(MIN_VAL, MIN_VAL, MIN_VAL);
        send_cell();
        fill_all(MAX_VAL, MIN_VAL, MIN_VAL);
        send_cell();
        fill_all(MIN_VAL, MAX_VAL, MAX_VAL);
        send_cell();
        // top moment untouched, cascade stops at once
        fill_all(1, 1000, 1000);
        send_cell();
        fill_all(-1, MIN_VAL, MIN_VAL);
        send_cell();
        // zero top moment lets the cascade go on
        set_level(3, '0, 500, 500);
        send_cell();
        fill_all(100000, 50, 60);
        send_cell();
        fill_all(-100000, -60, -50);
        send_cell();
        for (int k = 0; k < 4; k++) begin
            set_level(k, (k % 2) ? 32'sd70000 : -32'sd70000, (k % 2) ? 32'sd9 : -32'sd9,
                      (k % 2) ? 32'sd40000 : -32'sd40000);
        end
        send_cell();
        // clipped at the top two, untouched at the third
        fill_all(5000, 100, 100);
        set_level(1, 10, 1000, 1000);
        send_cell();
        fill_all(5000, 0, 300);
        send_cell();
        fill_all(-5000, -300, 300);
        send_cell();
        fill_all(MAX_VAL, 1, -1);
        send_cell();
        fill_all(MAX_VAL, 3, 2);
        send_cell();
        fill_all(MIN_VAL, -3, -2);
        send_cell();
        fill_all(MAX_VAL, MAX_VAL, 1);
        set_level(0, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555);
        send_cell();

        for (int p = 0; p < 8; p++) begin
            write_order(phase_order[p]);
            if (p == 0) hold_req = 1'b1;
            if (p == 7) idle_on = 1'b0;
            for (int i = 0; i < ((p == 7) ? LAST_CELLS : PHASE_CELLS); i++) begin
                gen_cell();
                send_cell();
            end
        end
        drain();

        $display("covered %0d cells over order settings 0 to 7, %0d through all four levels",
                 cells_sent, full_depth);
        $display("with idle bursts on both channels and a %0d-cycle receiver hold-off",
                 HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("PASS moment_limiter_cascade");
        end else begin
            $display("%0d mismatches over %0d results", fail_count, results);
            $display("FAIL moment_limiter_cascade");
        end
        $finish;
    end

endmodule
